@@ rtl/nbody_gravity_1d_euler_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the 1D gravity block
// Implication checks sampled on clk, held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef NBODY_GRAVITY_1D_EULER_ASSERT_SVH
`define NBODY_GRAVITY_1D_EULER_ASSERT_SVH

// same-cycle implication
`define NBG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nbody_gravity_1d_euler: assertion failed");

// next-cycle implication
`define NBG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nbody_gravity_1d_euler: assertion failed");

`endif

@@ rtl/nbg_pkg.sv @@
// ----------------------------------------------------------------------------
// nbg_pkg
// Shared constants, cell opcodes and sequencer states of the gravity block.
// ----------------------------------------------------------------------------
package nbg_pkg;

	localparam int MAX_PARTICLES_DEF = 16;
	localparam int POS_W   = 32;
	localparam int MASS_W  = 24;
	localparam int ACC_W   = 48;
	localparam int DT_W    = 32;
	localparam int STEPS_W = 16;
	localparam int PIDX_W  = 4;
	localparam int DIV_ITERS = 47;
	localparam int ITER_W  = 6;

	localparam logic [DT_W-1:0]    TIME_STEP_RST  = 32'd429497;
	localparam logic [STEPS_W-1:0] STEP_COUNT_RST = 16'd250;
	localparam logic [ITER_W-1:0]  ITER_LAST      = 6'(DIV_ITERS - 1);

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_TIME_STEP  = 1'b0,
		REG_STEP_COUNT = 1'b1
	} reg_idx_t;

	// operation broadcast to every cell
	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LOAD,
		OP_RING_LOAD,
		OP_DX,
		OP_SQ,
		OP_DIV_INIT,
		OP_DIV_ITER,
		OP_ACC,
		OP_RING_SHIFT,
		OP_UPD_MUL,
		OP_UPD_WR
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     run;   // integration in progress
	} cell_ctl_t;

	typedef enum logic [3:0] {
		S_LOAD,
		S_RING,
		S_DX,
		S_SQ,
		S_DINIT,
		S_DITER,
		S_ACC,
		S_SHIFT,
		S_UMUL,
		S_UWR,
		S_OLOAD,
		S_OUT
	} seq_state_t;

endpackage

@@ rtl/nbg_cell.sv @@
// ----------------------------------------------------------------------------
// nbg_cell
// One particle: position, velocity, mass, acceleration, a ring slot that
// passes a particle copy to the neighbor, and a bit-serial pair divider.
// ----------------------------------------------------------------------------
module nbg_cell #(
	parameter int MAXP = 16,
	parameter int IDX  = 0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  nbg_pkg::cell_ctl_t                   ctl,
	input  logic [$clog2(MAXP)-1:0]              k,
	input  logic [$clog2(MAXP+1)-1:0]            cnt,
	input  logic [nbg_pkg::DT_W-1:0]             dt,
	input  logic signed [nbg_pkg::POS_W-1:0]     ld_pos,
	input  logic [nbg_pkg::MASS_W-1:0]           ld_mass,
	input  logic signed [nbg_pkg::POS_W-1:0]     head_pos,
	input  logic [nbg_pkg::MASS_W-1:0]           head_mass,
	input  logic signed [nbg_pkg::POS_W-1:0]     nb_pos,
	input  logic [nbg_pkg::MASS_W-1:0]           nb_mass,
	output logic signed [nbg_pkg::POS_W-1:0]     src_pos,
	output logic [nbg_pkg::MASS_W-1:0]           src_mass,
	output logic                                 flag
);
	import nbg_pkg::*;

	localparam int KW = $clog2(MAXP);
	localparam int CW = $clog2(MAXP+1);
	localparam logic [CW-1:0] MY_CNT = CW'(IDX);
	localparam logic [KW-1:0] MY_K   = KW'(IDX);

	// particle state
	logic signed [31:0] pos_q, vel_q;
	logic [23:0]        mass_q;
	logic signed [47:0] acc_q;
	logic               flag_q;
	// ring slot
	logic signed [31:0] src_pos_q;
	logic [23:0]        src_mass_q;
	// pair datapath
	logic [31:0]        ad_q;
	logic               dneg_q, act_q, sat_q;
	logic [63:0]        d2_q, r_q;
	logic [46:0]        q_q;
	// update datapath
	logic [63:0]        pabs_q, hi_q, lo_q;
	logic               pneg_q, aneg_q;

	logic               valid, load_me;
	logic signed [32:0] dx;
	logic [32:0]        dx_abs;
	logic               same_k;
	logic [63:0]        sq, r_init, rs, r_next;
	logic               take;
	logic [46:0]        t;
	logic signed [48:0] term, acc_sum;
	logic signed [47:0] acc_new;
	logic               acc_ovf;
	logic signed [64:0] vprod;
	logic [64:0]        pabs_c;
	logic [47:0]        am;
	logic [63:0]        hi_c, lo_c, pround;
	logic [31:0]        pmag;
	logic signed [33:0] newp;
	logic [63:0]        lo_r;
	logic [64:0]        vsum;
	logic [44:0]        vmag;
	logic signed [47:0] newv;
	logic               p_hi, p_lo, v_hi, v_lo;

	assign valid   = MY_CNT < cnt;
	assign load_me = (ctl.op == OP_LOAD) && (cnt == MY_CNT);
	assign same_k  = (k == MY_K);

	// pair distance
	assign dx     = {pos_q[31], pos_q} - {head_pos[31], head_pos};
	assign dx_abs = dx[32] ? 33'(-dx) : 33'(dx);
	assign sq     = 64'(ad_q) * 64'(ad_q);

	// restoring divider, one quotient bit a cycle
	assign r_init = {15'b0, head_mass, 25'b0};
	assign rs     = {r_q[62:0], 1'b0};
	assign take   = r_q[63] || (rs >= d2_q);
	assign r_next = take ? (rs - d2_q) : rs;

	// saturating accumulate
	assign t       = sat_q ? {47{1'b1}} : q_q;
	assign term    = dneg_q ? 49'(signed'({2'b0, t})) : -49'(signed'({2'b0, t}));
	assign acc_sum = {acc_q[47], acc_q} + term;
	assign acc_ovf = acc_sum[48] != acc_sum[47];
	always_comb begin
		if (!acc_ovf) begin
			acc_new = acc_sum[47:0];
		end else if (acc_sum[48]) begin
			acc_new = {1'b1, 47'b0};
		end else begin
			acc_new = {1'b0, {47{1'b1}}};
		end
	end

	// update products
	assign vprod  = 65'(vel_q) * 65'(signed'({1'b0, dt}));
	assign pabs_c = vprod[64] ? 65'(-vprod) : 65'(vprod);
	assign am     = acc_q[47] ? 48'(-acc_q) : 48'(acc_q);
	assign hi_c   = 64'(am) * 64'(dt[31:16]);
	assign lo_c   = 64'(am) * 64'(dt[15:0]);

	// rounding and saturation of the new position and velocity
	assign pround = pabs_q + 64'h8000_0000;
	assign pmag   = pround[63:32];
	assign newp   = pneg_q ? ({{2{pos_q[31]}}, pos_q} - 34'(signed'({2'b0, pmag})))
	                       : ({{2{pos_q[31]}}, pos_q} + 34'(signed'({2'b0, pmag})));
	assign p_hi   = !newp[33] && (newp[32:31] != 2'b00);
	assign p_lo   = newp[33] && (newp[32:31] != 2'b11);
	assign lo_r   = (lo_q + (64'd1 << 35)) >> 16;
	assign vsum   = 65'(hi_q) + 65'(lo_r);
	assign vmag   = vsum[64:20];
	assign newv   = aneg_q ? ({{16{vel_q[31]}}, vel_q} - 48'(signed'({3'b0, vmag})))
	                       : ({{16{vel_q[31]}}, vel_q} + 48'(signed'({3'b0, vmag})));
	assign v_hi   = !newv[47] && (newv[46:31] != 16'h0000);
	assign v_lo   = newv[47] && (newv[46:31] != 16'hFFFF);

	// control state of the cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else begin
			unique case (ctl.op)
				OP_LOAD: begin
					if (load_me) flag_q <= 1'b0;
				end
				OP_DX: begin
					if (valid && !same_k && dx == 33'sd0) flag_q <= 1'b1;
				end
				OP_DIV_INIT: begin
					if (act_q && r_init >= d2_q) flag_q <= 1'b1;
				end
				OP_ACC: begin
					if (act_q && acc_ovf) flag_q <= 1'b1;
				end
				OP_UPD_WR: begin
					if (valid && (p_hi || p_lo || v_hi || v_lo)) flag_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_LOAD: begin
				if (load_me) begin
					pos_q  <= ld_pos;
					mass_q <= ld_mass;
					vel_q  <= '0;
				end
			end
			OP_RING_LOAD: begin
				src_pos_q  <= pos_q;
				src_mass_q <= mass_q;
				acc_q      <= '0;
			end
			OP_RING_SHIFT: begin
				src_pos_q  <= nb_pos;
				src_mass_q <= nb_mass;
			end
			OP_DX: begin
				ad_q   <= dx_abs[31:0];
				dneg_q <= dx[32];
				act_q  <= valid && !same_k && (dx != 33'sd0);
			end
			OP_SQ: begin
				d2_q <= sq;
			end
			OP_DIV_INIT: begin
				r_q   <= r_init;
				q_q   <= '0;
				sat_q <= r_init >= d2_q;
			end
			OP_DIV_ITER: begin
				r_q <= r_next;
				q_q <= {q_q[45:0], take};
			end
			OP_ACC: begin
				if (act_q) acc_q <= acc_new;
			end
			OP_UPD_MUL: begin
				pabs_q <= pabs_c[63:0];
				pneg_q <= vprod[64];
				hi_q   <= hi_c;
				lo_q   <= lo_c;
				aneg_q <= acc_q[47];
			end
			OP_UPD_WR: begin
				if (valid) begin
					priority if (p_hi) pos_q <= 32'sh7FFF_FFFF;
					else if (p_lo)     pos_q <= 32'sh8000_0000;
					else               pos_q <= newp[31:0];
					priority if (v_hi) vel_q <= 32'sh7FFF_FFFF;
					else if (v_lo)     vel_q <= 32'sh8000_0000;
					else               vel_q <= newv[31:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign src_pos  = src_pos_q;
	assign src_mass = src_mass_q;
	assign flag     = flag_q && valid && (ctl.run || !ctl.run);
endmodule

@@ rtl/nbg_ctrl.sv @@
// ----------------------------------------------------------------------------
// nbg_ctrl
// Sequencer: loads particles, walks pairs, steps and results, and issues
// one operation per cycle to the row of cells.
// ----------------------------------------------------------------------------
module nbg_ctrl #(
	parameter int MAXP = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              last_particle,
	input  logic                              out_ready,
	input  logic [nbg_pkg::STEPS_W-1:0]       step_count,
	output logic                              in_ready,
	output logic                              out_valid,
	output logic                              out_last,
	output logic [$clog2(MAXP)-1:0]           out_idx,
	output nbg_pkg::cell_ctl_t                ctl,
	output logic [$clog2(MAXP)-1:0]           k,
	output logic [$clog2(MAXP+1)-1:0]         cnt
);
	import nbg_pkg::*;

	localparam int KW = $clog2(MAXP);
	localparam int CW = $clog2(MAXP+1);

	seq_state_t         state_q, state_d;
	logic [CW-1:0]      cnt_q;
	logic [KW-1:0]      k_q, oidx_q;
	logic [ITER_W-1:0]  it_q;
	logic [STEPS_W-1:0] step_q;
	logic               accept, k_last, o_last, step_last;

	assign accept    = in_valid && (state_q == S_LOAD);
	assign k_last    = (CW'(k_q) + CW'(1)) == cnt_q;
	assign o_last    = (CW'(oidx_q) + CW'(1)) == cnt_q;
	assign step_last = step_q == (step_count - STEPS_W'(1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				if (accept && last_particle)
					state_d = (step_count == '0) ? S_OLOAD : S_RING;
			end
			S_RING:  state_d = S_DX;
			S_DX:    state_d = S_SQ;
			S_SQ:    state_d = S_DINIT;
			S_DINIT: state_d = S_DITER;
			S_DITER: begin
				if (it_q == ITER_LAST) state_d = S_ACC;
			end
			S_ACC:   state_d = S_SHIFT;
			S_SHIFT: state_d = k_last ? S_UMUL : S_DX;
			S_UMUL:  state_d = S_UWR;
			S_UWR:   state_d = step_last ? S_OLOAD : S_RING;
			S_OLOAD: state_d = S_OUT;
			S_OUT: begin
				if (out_ready && o_last) state_d = S_LOAD;
			end
			default: state_d = S_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		ctl.op  = OP_IDLE;
		ctl.run = (state_q != S_LOAD) && (state_q != S_OUT);
		unique case (state_q)
			S_LOAD:  if (accept && cnt_q < CW'(MAXP)) ctl.op = OP_LOAD;
			S_RING:  ctl.op = OP_RING_LOAD;
			S_DX:    ctl.op = OP_DX;
			S_SQ:    ctl.op = OP_SQ;
			S_DINIT: ctl.op = OP_DIV_INIT;
			S_DITER: ctl.op = OP_DIV_ITER;
			S_ACC:   ctl.op = OP_ACC;
			S_SHIFT: ctl.op = OP_RING_SHIFT;
			S_UMUL:  ctl.op = OP_UPD_MUL;
			S_UWR:   ctl.op = OP_UPD_WR;
			S_OLOAD: ctl.op = OP_RING_LOAD;
			S_OUT:   if (out_ready) ctl.op = OP_RING_SHIFT;
			default: ctl.op = OP_IDLE;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			k_q     <= '0;
			oidx_q  <= '0;
			it_q    <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.op == OP_LOAD) cnt_q <= cnt_q + CW'(1);
			if (state_q == S_RING) k_q <= '0;
			if (state_q == S_SHIFT && !k_last) k_q <= k_q + KW'(1);
			if (state_q == S_DINIT) it_q <= '0;
			if (state_q == S_DITER) it_q <= it_q + ITER_W'(1);
			if (state_q == S_UWR) step_q <= step_last ? '0 : step_q + STEPS_W'(1);
			if (state_q == S_OLOAD) oidx_q <= '0;
			if (state_q == S_OUT && out_ready) begin
				oidx_q <= oidx_q + KW'(1);
				if (o_last) cnt_q <= '0;
			end
		end
	end

	assign in_ready  = state_q == S_LOAD;
	assign out_valid = state_q == S_OUT;
	assign out_last  = o_last;
	assign out_idx   = oidx_q;
	assign k         = k_q;
	assign cnt       = cnt_q;
endmodule

@@ rtl/nbody_gravity_1d_euler.sv @@
// ----------------------------------------------------------------------------
// nbody_gravity_1d_euler
// Direct-sum 1D gravity with explicit Euler integration on a row of cells.
// ----------------------------------------------------------------------------
// Particles are loaded one per input transaction; the one marked last starts
// a run of step_count Euler steps, then one result per particle is sent in
// load order and the block loads a new set. Loading accepts one particle per
// cycle. In a run, every cell owns one particle and a bit-serial divider, all
// cells work on the same source particle at once, and the source copies
// rotate one cell per pair through the ring, so the bit-serial pair division
// dominates the run time. Results then leave at one per cycle when the
// receiver is ready.
module nbody_gravity_1d_euler
	import nbg_pkg::*;
#(
	parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [0:0]                        wr_index,
	input  logic [nbg_pkg::DT_W-1:0]          wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [nbg_pkg::POS_W-1:0]  position,
	input  logic [nbg_pkg::MASS_W-1:0]        mass,
	input  logic                              last_particle,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [nbg_pkg::PIDX_W-1:0]        particle_index,
	output logic signed [nbg_pkg::POS_W-1:0]  final_position,
	output logic                              collision_seen,
	output logic                              last_result
);
	`include "nbody_gravity_1d_euler_assert.svh"

	localparam int KW = $clog2(MAX_PARTICLES);
	localparam int CW = $clog2(MAX_PARTICLES+1);

	logic [DT_W-1:0]    time_step_q;
	logic [STEPS_W-1:0] step_count_q;
	cell_ctl_t          ctl;
	logic [KW-1:0]      k, out_idx;
	logic [CW-1:0]      cnt;
	logic signed [POS_W-1:0] src_pos [MAX_PARTICLES];
	logic [MASS_W-1:0]       src_mass[MAX_PARTICLES];
	logic [MAX_PARTICLES-1:0] flags;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q  <= TIME_STEP_RST;
			step_count_q <= STEP_COUNT_RST;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_TIME_STEP:  time_step_q  <= wr_data;
				REG_STEP_COUNT: step_count_q <= wr_data[STEPS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	nbg_ctrl #(.MAXP(MAX_PARTICLES)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.last_particle (last_particle),
		.out_ready     (out_ready),
		.step_count    (step_count_q),
		.in_ready      (in_ready),
		.out_valid     (out_valid),
		.out_last      (last_result),
		.out_idx       (out_idx),
		.ctl           (ctl),
		.k             (k),
		.cnt           (cnt)
	);

	// row of cells, ring closes from cell 0 back to the last cell
	for (genvar i = 0; i < MAX_PARTICLES; i++) begin : g_cell
		nbg_cell #(.MAXP(MAX_PARTICLES), .IDX(i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.k         (k),
			.cnt       (cnt),
			.dt        (time_step_q),
			.ld_pos    (position),
			.ld_mass   (mass),
			.head_pos  (src_pos[0]),
			.head_mass (src_mass[0]),
			.nb_pos    (src_pos[(i+1) % MAX_PARTICLES]),
			.nb_mass   (src_mass[(i+1) % MAX_PARTICLES]),
			.src_pos   (src_pos[i]),
			.src_mass  (src_mass[i]),
			.flag      (flags[i])
		);
	end

	// result payload comes from the ring head
	assign particle_index = PIDX_W'(out_idx);
	assign final_position = src_pos[0];
	assign collision_seen = |flags;

	`NBG_ASSERT_NOW(a_no_overlap, out_valid, !in_ready)
	`NBG_ASSERT_NEXT(a_run_starts, in_valid && in_ready && last_particle, !in_ready)
	`NBG_ASSERT_NEXT(a_reload, out_valid && out_ready && last_result, in_ready && !out_valid)
endmodule

@@ tb/tb_nbody_gravity_1d_euler.sv @@
// ----------------------------------------------------------------------------
// tb_nbody_gravity_1d_euler
// Self-checking bench for the 1D direct-sum gravity block: particle sets are
// loaded over the input channel and every final position is compared with a
// behavioral model of the fixed-point Euler integration.
// ----------------------------------------------------------------------------
module tb_nbody_gravity_1d_euler;
	import nbg_pkg::*;

	localparam int NSLOT = MAX_PARTICLES_DEF;
	localparam longint ACC_HI = 64'sd140737488355327;
	localparam longint ACC_LO = -ACC_HI - 1;
	localparam longint CYCLE_LIMIT = 20_000_000;

	typedef struct {
		logic [PIDX_W-1:0]        idx;
		logic signed [POS_W-1:0]  pos;
		logic                     coll;
		logic                     last;
	} orbit_result_t;

	// model of the integrator plus the queue of final positions still due
	class orbit_scoreboard;
		bit [DT_W-1:0]    dt = TIME_STEP_RST;
		bit [STEPS_W-1:0] nsteps = STEP_COUNT_RST;
		logic signed [POS_W-1:0] xs[NSLOT];
		logic signed [POS_W-1:0] vs[NSLOT];
		bit [MASS_W-1:0] ms[NSLOT];
		longint accs[NSLOT];
		int loaded = 0;
		bit anomaly = 0;
		orbit_result_t due_positions[$];
		int mismatches = 0;

		function void set_reg(reg_idx_t r, bit [DT_W-1:0] d);
			if (r == REG_TIME_STEP) dt = d;
			else nsteps = d[STEPS_W-1:0];
		endfunction

		function logic signed [POS_W-1:0] clamp32(longint v);
			if (v > 64'sd2147483647) begin
				anomaly = 1;
				return 32'sh7fffffff;
			end
			if (v < -64'sd2147483648) begin
				anomaly = 1;
				return 32'sh80000000;
			end
			return v[31:0];
		endfunction

		// floor(m * 2^72 / d2), bit serial, saturating
		function longint pull(bit [MASS_W-1:0] m, longint unsigned d2);
			longint unsigned r;
			longint unsigned q;
			bit carry;
			r = longint'(m) << 25;
			q = 0;
			if (r >= d2) begin
				anomaly = 1;
				return ACC_HI;
			end
			for (int i = 0; i < DIV_ITERS; i++) begin
				carry = r[63];
				r = r << 1;
				q = q << 1;
				if (carry || r >= d2) begin
					r = r - d2;
					q[0] = 1'b1;
				end
			end
			return longint'(q);
		endfunction

		function void euler_step();
			longint acc, dx, t, p, a;
			longint unsigned ad, mag, am, hi, lo;
			bit neg;
			for (int n = 0; n < loaded; n++) begin
				acc = 0;
				for (int k = 0; k < loaded; k++) begin
					if (k == n) continue;
					dx = longint'(xs[n]) - longint'(xs[k]);
					if (dx == 0) begin
						anomaly = 1;
						continue;
					end
					ad = (dx < 0) ? -dx : dx;
					t = pull(ms[k], ad * ad);
					acc += (dx > 0) ? -t : t;
					if (acc > ACC_HI) begin
						acc = ACC_HI;
						anomaly = 1;
					end
					if (acc < ACC_LO) begin
						acc = ACC_LO;
						anomaly = 1;
					end
				end
				accs[n] = acc;
			end
			for (int n = 0; n < loaded; n++) begin
				p = longint'(vs[n]) * longint'(dt);
				neg = p < 0;
				mag = neg ? -p : p;
				mag = (mag + (64'd1 << 31)) >> 32;
				xs[n] = clamp32(longint'(xs[n]) + (neg ? -longint'(mag) : longint'(mag)));
				a = accs[n];
				neg = a < 0;
				am = neg ? -a : a;
				hi = am * (dt >> 16);
				lo = am * (dt & 32'hffff);
				mag = (hi + ((lo + (64'd1 << 35)) >> 16)) >> 20;
				vs[n] = clamp32(longint'(vs[n]) + (neg ? -longint'(mag) : longint'(mag)));
			end
		endfunction

		// accepted input transaction
		function void note_particle(logic signed [POS_W-1:0] x, bit [MASS_W-1:0] m, bit fin);
			orbit_result_t r;
			if (loaded < NSLOT) begin
				xs[loaded] = x;
				ms[loaded] = m;
				vs[loaded] = 0;
				loaded++;
			end
			if (!fin) return;
			for (int s = 0; s < nsteps; s++) euler_step();
			for (int n = 0; n < loaded; n++) begin
				r.idx = n[PIDX_W-1:0];
				r.pos = xs[n];
				r.coll = anomaly;
				r.last = (n + 1 == loaded);
				due_positions.push_back(r);
			end
			loaded = 0;
			anomaly = 0;
			foreach (vs[i]) vs[i] = 0;
		endfunction

		function void check_result(orbit_result_t got);
			orbit_result_t want;
			if (due_positions.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result idx=%0d pos=%h", got.idx, got.pos);
				return;
			end
			want = due_positions.pop_front();
			if (got.idx !== want.idx || got.pos !== want.pos || got.coll !== want.coll
					|| got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp idx=%0d pos=%h coll=%b last=%b, got idx=%0d pos=%h coll=%b last=%b",
						want.idx, want.pos, want.coll, want.last,
						got.idx, got.pos, got.coll, got.last);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic wr_en = 0;
	logic [0:0] wr_index = REG_TIME_STEP;
	logic [DT_W-1:0] wr_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [POS_W-1:0] position = '0;
	logic [MASS_W-1:0] mass = '0;
	logic last_particle = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [PIDX_W-1:0] particle_index;
	logic signed [POS_W-1:0] final_position;
	logic collision_seen;
	logic last_result;

	orbit_scoreboard sb = new();
	int send_idle_pct = 19;
	int recv_idle_pct = 83;
	int hold_req = 0;
	longint cycles = 0;

	nbody_gravity_1d_euler dut (.*);

	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side: check on rising edge, pick next ready on falling edge
	initial begin
		int hold_left;
		orbit_result_t r;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				r.idx = particle_index;
				r.pos = final_position;
				r.coll = collision_seen;
				r.last = last_result;
				sb.check_result(r);
			end
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				out_ready <= 0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// one register write; enable drops at the next falling edge
	task automatic write_reg(reg_idx_t r, logic [DT_W-1:0] d);
		wr_en <= 1;
		wr_index <= r;
		wr_data <= d;
		@(negedge clk);
		wr_en <= 0;
		sb.set_reg(r, d);
		@(negedge clk);
	endtask

	// one input transaction; called and returns on a falling edge
	task automatic send_particle(logic signed [POS_W-1:0] x, logic [MASS_W-1:0] m, bit fin);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid <= 1;
		position <= x;
		mass <= m;
		last_particle <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_particle(x, m, fin);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.due_positions.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// random set: mostly plausible layouts, some raw noise, a few overfull
	task automatic random_set(inout int sent);
		int n;
		bit noisy;
		logic signed [POS_W-1:0] x;
		logic [MASS_W-1:0] m;
		n = ($urandom_range(9) == 0) ? $urandom_range(10, 18) : $urandom_range(1, 6);
		noisy = ($urandom_range(4) == 0);
		for (int i = 0; i < n; i++) begin
			if (noisy) begin
				x = $urandom;
				m = MASS_W'($urandom);
			end else begin
				x = $urandom >> $urandom_range(2, 8);
				if ($urandom_range(1)) x = -x;
				m = MASS_W'($urandom_range(0, 24'hffffff) >> $urandom_range(0, 12));
			end
			send_particle(x, m, i == n - 1);
			sent++;
		end
	endtask

	initial begin
		int sent;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// reset settings, two bodies one unit apart either side of origin
		send_particle(32'sh10000000, 24'h010000, 0);
		send_particle(-32'sh10000000, 24'h010000, 1);
		drain();

		// largest dt, one step: field extremes, zero mass, coincident pair
		write_reg(REG_TIME_STEP, 32'hffffffff);
		write_reg(REG_STEP_COUNT, 32'd1);
		send_particle(32'sh7fffffff, 24'hffffff, 0);
		send_particle(32'sh80000000, 24'h000000, 0);
		send_particle(32'sh00000000, 24'h000001, 0);
		send_particle(32'sh00000000, 24'h7fffff, 1);
		drain();

		// no steps: initial positions come back
		write_reg(REG_STEP_COUNT, 32'd0);
		send_particle(32'sh12345678, 24'h800000, 0);
		send_particle(-32'sh00000100, 24'h000100, 1);
		drain();

		// zero dt, lone particle
		write_reg(REG_TIME_STEP, 32'd0);
		write_reg(REG_STEP_COUNT, 32'd3);
		send_particle(32'sh01000000, 24'h010000, 1);
		drain();

		// overfull set: the seventeenth item is dropped but starts the run
		write_reg(REG_TIME_STEP, 32'd4294967);
		write_reg(REG_STEP_COUNT, 32'd1);
		for (int i = 0; i < 17; i++)
			send_particle($signed(32'(i * 32'h00900000 - 32'h08000000)),
				MASS_W'($urandom), i == 16);
		drain();

		// most steps, single particle keeps it short
		write_reg(REG_STEP_COUNT, 32'hffff);
		send_particle(32'sh00abcdef, 24'h123456, 1);
		drain();

		// short runs for the random part
		write_reg(REG_STEP_COUNT, 32'd2);

		// random part in three idling regimes
		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 19 : (mode == 1) ? 83 : 0;
			recv_idle_pct = (mode == 0) ? 83 : (mode == 1) ? 19 : 0;
			if (mode == 2) hold_req = 4000;
			sent = 0;
			while (sent < 40) begin
				if ($urandom_range(3) == 0) begin
					drain();
					write_reg(REG_TIME_STEP, $urandom_range(1) ? $urandom : $urandom >> 10);
					write_reg(REG_STEP_COUNT, $urandom_range(1, 5));
				end
				random_set(sent);
			end
			drain();
		end

		while (sb.due_positions.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (sb.mismatches == 0 && sb.due_positions.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
